### rtl/dct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types, codes and defaults for the DMA channel lifecycle tracker.
// ----------------------------------------------------------------------------
package dct_pkg;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEF   = 8;
  localparam int LIST_DEPTH_DEF = 16;

  // Width of the transfer-done mask, one bit per possible channel
  localparam int MASK_W = 8;

  // Configuration register indexes
  localparam logic [0:0] CFG_BLOCK_LIMIT = 1'b0;
  localparam logic [0:0] CFG_LIST_MODE   = 1'b1;
  localparam int         CFG_DATA_W      = 12;
  localparam logic [CFG_DATA_W-1:0] BLOCK_LIMIT_RST = 12'd4095;

  // Request codes; code 7 has no meaning and is rejected
  typedef enum logic [2:0] {
    REQ_CONFIGURE = 3'd0,
    REQ_START     = 3'd1,
    REQ_STOP      = 3'd2,
    REQ_SUSPEND   = 3'd3,
    REQ_RESUME    = 3'd4,
    REQ_DONE      = 3'd5,
    REQ_STATUS    = 3'd6
  } req_code_t;

  // Status codes returned with every result
  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_INVALID = 2'd1,
    RC_BUSY    = 2'd2,
    RC_OVERRUN = 2'd3
  } rc_t;

  // Transfer directions
  localparam logic [1:0] DIR_M2M = 2'd0;
  localparam logic [1:0] DIR_M2P = 2'd1;
  localparam logic [1:0] DIR_P2M = 2'd2;
  localparam logic [1:0] DIR_BAD = 2'd3;

  // Per-channel lifecycle state, one-hot
  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_PREPARED  = 4'b0010,
    ST_ACTIVE    = 4'b0100,
    ST_SUSPENDED = 4'b1000
  } chan_state_t;

  // Request item
  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  channel;
    logic        hw_enabled;
    logic [1:0]  direction;
    logic [4:0]  data_size;
    logic [4:0]  list_len;
    logic [15:0] largest_block;
    logic [31:0] total_bytes;
    logic [31:0] start_address;
    logic [31:0] hw_pointer;
    logic [7:0]  done_mask;
  } req_t;

  // Result item
  typedef struct packed {
    logic [1:0]  status_code;
    logic [1:0]  channel_state;
    logic [31:0] pending_bytes;
    logic [31:0] free_bytes;
  } rsp_t;

  // Stored record of one channel
  typedef struct packed {
    chan_state_t state;
    logic [1:0]  dir;
    logic [31:0] ring_len;
    logic [31:0] sw_ptr;
    logic [31:0] last_hw_ptr;
  } chan_rec_t;

  // Update of the channel store from one request
  typedef struct packed {
    logic [MASK_W-1:0] clear_mask;
    logic              state_we;
    chan_state_t       state;
    logic              setup_we;
    logic [1:0]        dir;
    logic [31:0]       ring_len;
    logic [31:0]       sw_ptr;
    logic              hwp_we;
    logic [31:0]       hwp;
  } chan_upd_t;

  // Dense two-bit code of a lifecycle state
  function automatic logic [1:0] state_code(input chan_state_t s);
    logic [1:0] c;
    unique case (s)
      ST_IDLE:      c = 2'd0;
      ST_PREPARED:  c = 2'd1;
      ST_ACTIVE:    c = 2'd2;
      ST_SUSPENDED: c = 2'd3;
      default:      c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/dct_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_stream_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface dct_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/dma_channel_lifecycle_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_channel_lifecycle_tracker
// Per-channel DMA lifecycle state machine with ring occupancy reporting.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request items (configure, start, stop, suspend, resume,
//          transfer done, status), valid/ready, sink side.
//   rsp  - one result item per request: status code, channel state after
//          the request, pending and free ring bytes (status queries only).
//   cfg_we/cfg_index/cfg_data - register writes: index 0 block size limit,
//          index 1 hardware list mode. Write only while no request is in
//          flight.
// Pipeline: a request accepted into the input register is decided and has
//   its result registered in the result register once that register can advance.
// Throughput: one request per cycle while rsp is not held off; the channel
//   record is read and written back in the same cycle as the result is formed.
// Reset: all channels idle, stored direction, ring length and pointers
//   zero, block size limit 4095, list mode off; both stages empty.
// Stall: while rsp is held off, the result register holds its item; one
//   more request is still taken into the input register, then req.ready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
module dma_channel_lifecycle_tracker #(
  parameter int CHANNELS   = dct_pkg::CHANNELS_DEF,
  parameter int LIST_DEPTH = dct_pkg::LIST_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dct_stream_if.sink                    req,
  dct_stream_if.source                  rsp,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [dct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dct_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [CFG_DATA_W-1:0] block_limit;
  logic                  list_mode;

  // Channel store
  chan_state_t chan_state      [CHANNELS];
  logic [1:0]  chan_direction  [CHANNELS];
  logic [31:0] ring_length     [CHANNELS];
  logic [31:0] software_pointer[CHANNELS];
  logic [31:0] last_hw_pointer [CHANNELS];

  // Pipeline registers
  logic      in_valid;
  req_t      in_item;
  logic      out_valid;
  rsp_t      out_item;

  logic      advance;
  logic      in_take;
  logic      chan_ok;
  logic [CH_W-1:0] idx;
  chan_rec_t rec;
  rsp_t      step_rsp;
  chan_upd_t upd;

  // Handshake
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = !in_valid || advance;
  assign in_take   = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_limit <= BLOCK_LIMIT_RST;
      list_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_LIMIT: block_limit <= cfg_data;
        CFG_LIST_MODE:   list_mode   <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item <= req.data;
    end
  end

  // Record of the addressed channel
  assign chan_ok = in_item.channel < 4'(CHANNELS);
  assign idx     = chan_ok ? in_item.channel[CH_W-1:0] : '0;

  always_comb begin
    rec.state       = chan_state[idx];
    rec.dir         = chan_direction[idx];
    rec.ring_len    = ring_length[idx];
    rec.sw_ptr      = software_pointer[idx];
    rec.last_hw_ptr = last_hw_pointer[idx];
  end

  dct_step #(
    .CHANNELS  (CHANNELS),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_step (
    .req        (in_item),
    .rec        (rec),
    .block_limit(block_limit),
    .list_mode  (list_mode),
    .rsp        (step_rsp),
    .upd        (upd)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_item <= step_rsp;
    end
  end

  // Channel store write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_state[i]       <= ST_IDLE;
        chan_direction[i]   <= DIR_M2M;
        ring_length[i]      <= 32'd0;
        software_pointer[i] <= 32'd0;
        last_hw_pointer[i]  <= 32'd0;
      end
    end else if (advance && in_valid) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (upd.clear_mask[i]) begin
          chan_state[i] <= ST_IDLE;
        end else if (upd.state_we && idx == CH_W'(i)) begin
          chan_state[i] <= upd.state;
        end
        if (upd.setup_we && idx == CH_W'(i)) begin
          chan_direction[i]   <= upd.dir;
          ring_length[i]      <= upd.ring_len;
          software_pointer[i] <= upd.sw_ptr;
        end
        if (upd.hwp_we && idx == CH_W'(i)) begin
          last_hw_pointer[i] <= upd.hwp;
        end
      end
    end
  end

  // Checks
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (in_valid && out_valid && !rsp.ready))
    else $error("request side stalled without a stalled result");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> out_valid)
    else $error("processed item did not reach the result register");

  a_overrun_needs_list_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status_code == RC_OVERRUN) |-> list_mode)
    else $error("overrun reported with list mode off");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!in_valid && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

### rtl/dct_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_step
// Decision logic for one request: checks, next channel state, ring occupancy.
// ----------------------------------------------------------------------------
module dct_step #(
  parameter int CHANNELS   = dct_pkg::CHANNELS_DEF,
  parameter int LIST_DEPTH = dct_pkg::LIST_DEPTH_DEF
) (
  input  dct_pkg::req_t             req,
  input  dct_pkg::chan_rec_t        rec,
  input  logic [dct_pkg::CFG_DATA_W-1:0] block_limit,
  input  logic                      list_mode,
  output dct_pkg::rsp_t             rsp,
  output dct_pkg::chan_upd_t        upd
);
  import dct_pkg::*;

  // Mask of the channels that exist
  localparam logic [MASK_W-1:0] CH_MASK = MASK_W'((9'd1 << CHANNELS) - 9'd1);

  logic        chan_valid;
  logic        cfg_bad;
  rc_t         rc;
  chan_state_t st_next;
  chan_state_t st_after;
  logic [31:0] diff;
  logic [31:0] ring_dist;
  logic [31:0] other;
  logic        moved;
  logic        src_side;
  logic [31:0] pend_cnt;
  logic [31:0] free_cnt;

  assign chan_valid = req.channel < 4'(CHANNELS);

  // Configure parameter checks
  assign cfg_bad = !(req.data_size == 5'd1 || req.data_size == 5'd2 ||
                     req.data_size == 5'd4) ||
                   req.list_len == 5'd0 ||
                   req.list_len > 5'(LIST_DEPTH) ||
                   req.direction == DIR_BAD ||
                   req.largest_block > {4'd0, block_limit};

  // Ring distance, full when the pointers meet after the hardware moved
  assign diff     = req.hw_pointer - rec.sw_ptr;
  assign moved    = req.hw_pointer != rec.last_hw_ptr;
  assign src_side = rec.dir == DIR_M2P || rec.dir == DIR_BAD;

  always_comb begin
    if (diff[31]) begin
      ring_dist = diff + rec.ring_len;
    end else if (diff == 32'd0 && moved) begin
      ring_dist = rec.ring_len;
    end else begin
      ring_dist = diff;
    end
  end

  assign other = rec.ring_len - ring_dist;

  // Request decode
  always_comb begin
    rc           = RC_OK;
    st_next      = rec.state;
    upd          = '0;
    upd.state    = rec.state;
    upd.dir      = req.direction;
    upd.ring_len = req.total_bytes;
    upd.sw_ptr   = req.start_address;
    upd.hwp      = req.hw_pointer;
    pend_cnt     = 32'd0;
    free_cnt     = 32'd0;

    if (req.req_type == REQ_DONE) begin
      upd.clear_mask = req.done_mask & CH_MASK;
    end else if (!chan_valid) begin
      rc = RC_INVALID;
    end else begin
      unique case (req.req_type)
        REQ_CONFIGURE: begin
          if (rec.state == ST_ACTIVE || rec.state == ST_SUSPENDED) begin
            rc = RC_BUSY;
          end else if (cfg_bad) begin
            rc = RC_INVALID;
          end else begin
            st_next      = ST_PREPARED;
            upd.setup_we = 1'b1;
            upd.hwp_we   = 1'b1;
            upd.hwp      = req.start_address;
          end
        end
        REQ_START: begin
          // An already running channel is left alone
          if (!req.hw_enabled) begin
            if (rec.state != ST_PREPARED) begin
              rc = RC_BUSY;
            end else begin
              st_next = ST_ACTIVE;
            end
          end
        end
        REQ_STOP: begin
          // Stopped in hardware and not suspended: nothing to do
          if (req.hw_enabled || rec.state == ST_SUSPENDED) begin
            if (rec.state != ST_ACTIVE && rec.state != ST_SUSPENDED) begin
              rc = RC_INVALID;
            end else begin
              st_next = ST_IDLE;
            end
          end
        end
        REQ_SUSPEND: begin
          if (rec.state != ST_ACTIVE) begin
            rc = RC_INVALID;
          end else begin
            st_next = ST_SUSPENDED;
          end
        end
        REQ_RESUME: begin
          if (rec.state != ST_SUSPENDED) begin
            rc = RC_INVALID;
          end else begin
            st_next = ST_ACTIVE;
          end
        end
        REQ_STATUS: begin
          upd.hwp_we = 1'b1;
          if (src_side) begin
            free_cnt = ring_dist;
            pend_cnt = other;
          end else begin
            pend_cnt = ring_dist;
            free_cnt = other;
          end
          if (list_mode && !req.hw_enabled) begin
            rc = RC_OVERRUN;
          end
        end
        default: begin
          rc = RC_INVALID;
        end
      endcase
    end

    upd.state_we = st_next != rec.state;
    upd.state    = st_next;
  end

  // State of the addressed channel once the request has taken effect
  always_comb begin
    if (req.req_type == REQ_DONE && req.done_mask[req.channel[2:0]]) begin
      st_after = ST_IDLE;
    end else begin
      st_after = st_next;
    end
  end

  assign rsp = '{status_code:   rc,
                 channel_state: chan_valid ? state_code(st_after) : 2'd0,
                 pending_bytes: pend_cnt,
                 free_bytes:    free_cnt};

endmodule

### dv/dct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_checker
// Scoreboard for the DMA channel lifecycle tracker. Follows every accepted
// request and register write, keeps its own copy of each channel's lifecycle
// state and ring pointers, and compares each returned item, field by field
// and in order, with the predicted status.
// ----------------------------------------------------------------------------
module dct_checker #(
  parameter int NCH   = dct_pkg::CHANNELS_DEF,
  parameter int DEPTH = dct_pkg::LIST_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_ready,
  input  dct_pkg::req_t                  req_data,
  input  logic                           rsp_valid,
  input  logic                           rsp_ready,
  input  dct_pkg::rsp_t                  rsp_data,
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [dct_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             in_flight
);
  import dct_pkg::*;

  // Dense lifecycle codes, as reported in channel_state
  typedef enum logic [1:0] {
    LC_IDLE      = 2'd0,
    LC_PREPARED  = 2'd1,
    LC_ACTIVE    = 2'd2,
    LC_SUSPENDED = 2'd3
  } life_t;

  life_t                 ch_life [NCH];
  logic [1:0]            ch_dir  [NCH];
  logic [31:0]           ch_len  [NCH];
  logic [31:0]           ch_sw   [NCH];
  logic [31:0]           ch_hwp  [NCH];
  logic [CFG_DATA_W-1:0] blk_limit;
  logic                  list_mode;

  rsp_t status_q [$];
  rsp_t want;

  // Apply one request to the channel copy and return the status it yields
  function automatic rsp_t track_request(input req_t r);
    rsp_t        o;
    life_t       s;
    logic [31:0] moved;
    logic [31:0] ring_dist;
    int          c;
    int          i;
    o = '0;
    c = int'(r.channel);
    if (r.req_type == REQ_DONE) begin
      // channel field unused; each set bit below NCH idles that channel
      for (i = 0; i < NCH; i++)
        if (r.done_mask[i]) ch_life[i] = LC_IDLE;
    end else if (c >= NCH) begin
      o.status_code = RC_INVALID;
    end else begin
      s = ch_life[c];
      case (r.req_type)
        REQ_CONFIGURE: begin
          if (s == LC_ACTIVE || s == LC_SUSPENDED) begin
            o.status_code = RC_BUSY;
          end else if (!(r.data_size == 5'd1 || r.data_size == 5'd2 ||
                         r.data_size == 5'd4) ||
                       r.list_len == 5'd0 || int'(r.list_len) > DEPTH ||
                       r.direction == DIR_BAD ||
                       r.largest_block > {4'd0, blk_limit}) begin
            // rejected setup leaves the channel as it was
            o.status_code = RC_INVALID;
          end else begin
            ch_life[c] = LC_PREPARED;
            ch_dir[c]  = r.direction;
            ch_len[c]  = r.total_bytes;
            ch_sw[c]   = r.start_address;
            ch_hwp[c]  = r.start_address;
          end
        end
        REQ_START: begin
          // already running in hardware: nothing to do
          if (!r.hw_enabled) begin
            if (s != LC_PREPARED) o.status_code = RC_BUSY;
            else ch_life[c] = LC_ACTIVE;
          end
        end
        REQ_STOP: begin
          // disabled and not suspended: already stopped
          if (r.hw_enabled || s == LC_SUSPENDED) begin
            if (s == LC_ACTIVE || s == LC_SUSPENDED) ch_life[c] = LC_IDLE;
            else o.status_code = RC_INVALID;
          end
        end
        REQ_SUSPEND: begin
          if (s != LC_ACTIVE) o.status_code = RC_INVALID;
          else ch_life[c] = LC_SUSPENDED;
        end
        REQ_RESUME: begin
          if (s != LC_SUSPENDED) o.status_code = RC_INVALID;
          else ch_life[c] = LC_ACTIVE;
        end
        REQ_STATUS: begin
          moved     = r.hw_pointer - ch_hwp[c];
          ch_hwp[c] = r.hw_pointer;
          ring_dist = r.hw_pointer - ch_sw[c];
          // negative distance wraps; equal pointers after a move mean full
          if (ring_dist[31]) ring_dist = ring_dist + ch_len[c];
          else if (ring_dist == 32'd0 && moved != 32'd0) ring_dist = ch_len[c];
          if (ch_dir[c] == DIR_M2M || ch_dir[c] == DIR_P2M) begin
            o.pending_bytes = ring_dist;
            o.free_bytes    = ch_len[c] - ring_dist;
          end else begin
            o.free_bytes    = ring_dist;
            o.pending_bytes = ch_len[c] - ring_dist;
          end
          if (list_mode && !r.hw_enabled) o.status_code = RC_OVERRUN;
        end
        default: o.status_code = RC_INVALID;
      endcase
    end
    if (c < NCH) o.channel_state = ch_life[c];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // Register writes, result compare, then prediction of the new request
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        ch_life[i] = LC_IDLE;
        ch_dir[i]  = DIR_M2M;
        ch_len[i]  = '0;
        ch_sw[i]   = '0;
        ch_hwp[i]  = '0;
      end
      blk_limit = BLOCK_LIMIT_RST;
      list_mode = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BLOCK_LIMIT) blk_limit = cfg_data;
        else list_mode = cfg_data[0];
      end
      if (rsp_valid && rsp_ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: result with nothing expected: got %0h", $time, rsp_data);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("status_code", 32'(want.status_code), 32'(rsp_data.status_code));
          check_field("channel_state", 32'(want.channel_state),
                      32'(rsp_data.channel_state));
          check_field("pending_bytes", want.pending_bytes, rsp_data.pending_bytes);
          check_field("free_bytes", want.free_bytes, rsp_data.free_bytes);
        end
      end
      if (req_valid && req_ready) status_q.push_back(track_request(req_data));
    end
    in_flight = status_q.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Top of the DMA channel lifecycle tracker bench. Drives a directed pass over
// the request checks, then random lifecycle sequences mixed with raw noise
// under several register settings and idle/stall mixes; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import dct_pkg::*;

  localparam logic [2:0] REQ_UNDEFINED  = 3'd7;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 4;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [0:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [CFG_DATA_W-1:0] limit_now;
  int                    idle_pct;
  int                    stall_pct;
  int                    sent;
  int                    stuck_cycles;
  int                    mismatches;
  int                    in_flight;
  req_t                  d;

  dct_stream_if #(.T(req_t)) req_if ();
  dct_stream_if #(.T(rsp_t)) rsp_if ();

  dma_channel_lifecycle_tracker u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dct_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_if.valid),
    .req_ready  (req_if.ready),
    .req_data   (req_if.data),
    .rsp_valid  (rsp_if.valid),
    .rsp_ready  (rsp_if.ready),
    .rsp_data   (rsp_if.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: too long without any item or write moving
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic req_t blank(input logic [2:0] kind, input logic [3:0] ch);
    req_t r;
    r          = '0;
    r.req_type = kind;
    r.channel  = ch;
    return r;
  endfunction

  // Every field fully random, unknown request code included
  function automatic req_t noise_req();
    req_t r;
    r.req_type      = 3'($urandom_range(0, 7));
    r.channel       = 4'($urandom_range(0, 15));
    r.hw_enabled    = 1'($urandom_range(0, 1));
    r.direction     = 2'($urandom_range(0, 3));
    r.data_size     = 5'($urandom_range(0, 31));
    r.list_len      = 5'($urandom_range(0, 31));
    r.largest_block = 16'($urandom_range(0, 65535));
    r.total_bytes   = $urandom;
    r.start_address = $urandom;
    r.hw_pointer    = $urandom;
    r.done_mask     = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Present one request, with random idle cycles ahead of it; enter and leave at negedge
  task automatic send_item(input req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Hold off requests until every predicted status has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_BLOCK_LIMIT) limit_now = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One channel through setup, start, a few status/suspend/resume steps and teardown
  task automatic lifecycle_burst();
    req_t        r;
    logic [3:0]  ch;
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] hwp;
    int          steps;
    ch    = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    base  = ($urandom_range(0, 3) == 0) ? 32'd0 - 32'($urandom_range(0, 2048)) : $urandom;
    len   = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(1, 4096));
    hwp   = base;
    r               = noise_req();
    r.req_type      = REQ_CONFIGURE;
    r.channel       = ch;
    case ($urandom_range(0, 2))
      0:       r.data_size = 5'd1;
      1:       r.data_size = 5'd2;
      default: r.data_size = 5'd4;
    endcase
    r.list_len      = 5'($urandom_range(1, LIST_DEPTH_DEF));
    r.direction     = 2'($urandom_range(0, 2));
    r.largest_block = 16'($urandom_range(0, limit_now));
    r.total_bytes   = len;
    r.start_address = base;
    // occasional broken setup
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       r.data_size = 5'd3;
        1:       r.list_len = '0;
        2:       r.direction = DIR_BAD;
        default: r.largest_block = 16'(limit_now) + 16'($urandom_range(1, 1000));
      endcase
    end
    send_item(r);
    r            = noise_req();
    r.req_type   = REQ_START;
    r.channel    = ch;
    r.hw_enabled = ($urandom_range(0, 7) == 0);
    send_item(r);
    steps = $urandom_range(1, 6);
    repeat (steps) begin
      r         = noise_req();
      r.channel = ch;
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          r.req_type   = REQ_STATUS;
          r.hw_enabled = ($urandom_range(0, 3) != 0);
          case ($urandom_range(0, 4))
            0:       r.hw_pointer = base;
            1:       r.hw_pointer = base + 32'($urandom_range(0, len));
            2:       r.hw_pointer = base - 32'($urandom_range(1, 64));
            3:       r.hw_pointer = hwp;
            default: r.hw_pointer = $urandom;
          endcase
          hwp = r.hw_pointer;
        end
        3: r.req_type = REQ_SUSPEND;
        4: r.req_type = REQ_RESUME;
        default: begin
          r.req_type   = REQ_START;
          r.hw_enabled = 1'b0;
        end
      endcase
      send_item(r);
    end
    // teardown by stop or by transfer-done interrupt
    r         = noise_req();
    r.channel = ch;
    if ($urandom_range(0, 1) == 0) begin
      r.req_type = REQ_STOP;
    end else begin
      r.req_type           = REQ_DONE;
      r.done_mask[ch[2:0]] = 1'b1;
    end
    send_item(r);
  endtask

  task automatic run_phase(input int count, input int idle, input int stall);
    int stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = sent + count;
    while (sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) send_item(noise_req());
      else lifecycle_burst();
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_BLOCK_LIMIT;
    cfg_data     = '0;
    rst          = 1'b1;
    idle_pct     = 0;
    stall_pct    = 0;
    sent         = 0;
    stuck_cycles = 0;
    limit_now    = BLOCK_LIMIT_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: status of an untouched channel
    d = blank(REQ_STATUS, 4'd0);
    d.hw_enabled = 1'b1;
    send_item(d);
    // setup checks: element size, list length, direction, block size
    d = blank(REQ_CONFIGURE, 4'd0);
    d.data_size = 5'd3;
    d.list_len  = 5'd1;
    send_item(d);
    d.data_size = 5'd4;
    d.list_len  = 5'd0;
    send_item(d);
    d.list_len = 5'(LIST_DEPTH_DEF + 1);
    send_item(d);
    d.list_len  = 5'd1;
    d.direction = DIR_BAD;
    send_item(d);
    d.direction     = DIR_P2M;
    d.largest_block = 16'(BLOCK_LIMIT_RST) + 16'd1;
    send_item(d);
    // good setup at the limits, ring wrapping through address zero
    d.largest_block = 16'(BLOCK_LIMIT_RST);
    d.list_len      = 5'(LIST_DEPTH_DEF);
    d.total_bytes   = 32'h100;
    d.start_address = 32'hFFFF_FF80;
    send_item(d);
    // start while enabled in hardware, then a real start
    d = blank(REQ_START, 4'd0);
    d.hw_enabled = 1'b1;
    send_item(d);
    d.hw_enabled = 1'b0;
    send_item(d);
    // setup while active
    d = blank(REQ_CONFIGURE, 4'd0);
    d.data_size = 5'd1;
    d.list_len  = 5'd1;
    send_item(d);
    // occupancy: unmoved, across the wrap, full after a move, behind the start
    d = blank(REQ_STATUS, 4'd0);
    d.hw_enabled = 1'b1;
    d.hw_pointer = 32'hFFFF_FF80;
    send_item(d);
    d.hw_pointer = 32'h0000_0040;
    send_item(d);
    d.hw_pointer = 32'hFFFF_FF80;
    send_item(d);
    d.hw_pointer = 32'hFFFF_FF00;
    send_item(d);
    // suspend / resume, then stop a suspended channel that hardware shows disabled
    send_item(blank(REQ_SUSPEND, 4'd0));
    send_item(blank(REQ_RESUME, 4'd0));
    send_item(blank(REQ_SUSPEND, 4'd0));
    send_item(blank(REQ_STOP, 4'd0));
    // wrong-state requests on an idle channel
    send_item(blank(REQ_START, 4'd1));
    d = blank(REQ_STOP, 4'd1);
    d.hw_enabled = 1'b1;
    send_item(d);
    send_item(blank(REQ_SUSPEND, 4'd1));
    // out-of-range channel and the unknown request code
    d = blank(REQ_CONFIGURE, 4'd8);
    d.data_size = 5'd2;
    d.list_len  = 5'd1;
    send_item(d);
    send_item(blank(REQ_UNDEFINED, 4'd2));
    // transfer-done ignores the channel field
    d = blank(REQ_CONFIGURE, 4'd7);
    d.data_size = 5'd2;
    d.list_len  = 5'd1;
    d.direction = DIR_M2P;
    send_item(d);
    send_item(blank(REQ_START, 4'd7));
    d = blank(REQ_DONE, 4'd15);
    d.done_mask = 8'hFF;
    send_item(d);

    // Random phases, registers changed only with nothing in flight
    drain();
    write_reg(CFG_BLOCK_LIMIT, 12'd1);
    write_reg(CFG_LIST_MODE, 12'd1);
    run_phase(250, 0, 0);

    drain();
    write_reg(CFG_BLOCK_LIMIT, BLOCK_LIMIT_RST);
    write_reg(CFG_LIST_MODE, 12'd0);
    run_phase(250, 76, 0);

    drain();
    write_reg(CFG_BLOCK_LIMIT, 12'($urandom_range(2, 4094)));
    write_reg(CFG_LIST_MODE, 12'd1);
    run_phase(250, 0, 76);

    drain();
    write_reg(CFG_BLOCK_LIMIT, BLOCK_LIMIT_RST);
    run_phase(275, 32, 32);

    drain();
    if (mismatches == 0 && in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/dct_pkg.sv
rtl/dct_stream_if.sv
rtl/dct_step.sv
rtl/dma_channel_lifecycle_tracker.sv
dv/dct_checker.sv
dv/testbench.sv
